>>> sv/stw_pkg.sv
// ----------------------------------------------------------------------------
// Strided tensor walker package
// Register indexes, configuration port widths and the packed field helper
// used by the walker and its offset lanes.
// ----------------------------------------------------------------------------
`default_nettype none

package stw_pkg;

    localparam int CFG_IDX_BITS   = 4;
    localparam int CFG_DATA_BITS  = 64;
    localparam int RANK_BITS      = 3;
    localparam int FIELD_MAX_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] CFG_RANK        = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EXTENTS     = 4'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SRC_A_BASE  = 4'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SRC_B_BASE  = 4'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DST_BASE    = 4'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_A_STRIDES   = 4'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_B_STRIDES   = 4'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OUT_STRIDES = 4'd7;

    // Returns the field of the given width that starts at bit position shift.
    // A field that starts past the top of the word reads as zero.
    function automatic logic [FIELD_MAX_BITS-1:0] f_packed_field(
        input logic [CFG_DATA_BITS-1:0] word,
        input int unsigned              shift,
        input int unsigned              bits
    );
        logic [CFG_DATA_BITS-1:0] tmp;
        logic [CFG_DATA_BITS-1:0] mask;
        tmp  = '0;
        mask = (CFG_DATA_BITS'(1) << bits) - CFG_DATA_BITS'(1);
        if (shift < CFG_DATA_BITS) begin
            tmp = (word >> shift) & mask;
        end
        return tmp[FIELD_MAX_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

>>> sv/stw_ifaces.sv
// ----------------------------------------------------------------------------
// Strided tensor walker channels
// Valid/ready channels for configuration writes, advance requests and
// offset results.
// ----------------------------------------------------------------------------
`default_nettype none

interface stw_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [stw_pkg::CFG_IDX_BITS-1:0]    index;
    logic [stw_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface stw_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, restart, input ready);
    modport sink   (input valid, restart, output ready);
endinterface

interface stw_rsp_if #(
    parameter int OFFSET_BITS = 32
);
    logic                   valid;
    logic                   ready;
    logic [OFFSET_BITS-1:0] src_a_ofs;
    logic [OFFSET_BITS-1:0] src_b_ofs;
    logic [OFFSET_BITS-1:0] dst_ofs;
    logic                   last;

    modport source (output valid, src_a_ofs, src_b_ofs, dst_ofs, last, input ready);
    modport sink   (input valid, src_a_ofs, src_b_ofs, dst_ofs, last, output ready);
endinterface

`default_nettype wire

>>> sv/stw_offset_lane.sv
// ----------------------------------------------------------------------------
// Strided tensor walker offset lane
// Forms base + sum(index * stride) for one tensor over two register stages:
// per-dimension products, then the sum with the base.
// ----------------------------------------------------------------------------
`default_nettype none

module stw_offset_lane #(
    parameter int MAX_RANK    = 4,
    parameter int EXTENT_BITS = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_ld_prod,
    input  logic                                   i_ld_sum,
    input  logic [MAX_RANK-1:0][EXTENT_BITS-1:0]   i_idx,
    input  logic [stw_pkg::CFG_DATA_BITS-1:0]      i_strides,
    input  logic [OFFSET_BITS-1:0]                 i_base,
    output logic [OFFSET_BITS-1:0]                 o_offset
);

    localparam int PROD_BITS = 2 * EXTENT_BITS + 1;
    localparam int WIDE_BITS = (PROD_BITS > OFFSET_BITS) ? PROD_BITS : OFFSET_BITS;

    logic [MAX_RANK-1:0][EXTENT_BITS-1:0] stride_fld;
    logic [MAX_RANK-1:0][OFFSET_BITS-1:0] n_prod;
    logic [MAX_RANK-1:0][OFFSET_BITS-1:0] r_prod;
    logic [OFFSET_BITS-1:0]               n_sum;
    logic [OFFSET_BITS-1:0]               r_sum;

    for (genvar d = 0; d < MAX_RANK; d++) begin : g_fld
        localparam int unsigned SHIFT = (MAX_RANK - 1 - d) * EXTENT_BITS;
        assign stride_fld[d] = EXTENT_BITS'(stw_pkg::f_packed_field(i_strides, SHIFT,
                                                                    EXTENT_BITS));
    end

    // The index is unsigned and the stride signed; the product is
    // sign-extended or truncated to the offset width, which gives the
    // wrap-around result of the unsigned sum.
    always_comb begin
        logic signed [EXTENT_BITS:0]   a_op;
        logic signed [EXTENT_BITS-1:0] b_op;
        logic signed [PROD_BITS-1:0]   prod;
        logic signed [WIDE_BITS-1:0]   wide;
        for (int d = 0; d < MAX_RANK; d++) begin
            a_op      = $signed({1'b0, i_idx[d]});
            b_op      = $signed(stride_fld[d]);
            prod      = a_op * b_op;
            wide      = prod;
            n_prod[d] = wide[OFFSET_BITS-1:0];
        end
    end

    always_comb begin
        n_sum = i_base;
        for (int d = 0; d < MAX_RANK; d++) begin
            n_sum = n_sum + r_prod[d];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld_prod) begin
            r_prod <= n_prod;
        end
        if (i_ld_sum) begin
            r_sum <= n_sum;
        end
    end

    assign o_offset = r_sum;

endmodule

`default_nettype wire

>>> sv/strided_tensor_address_walker.sv
// ----------------------------------------------------------------------------
// Strided tensor address walker
// Row-major odometer over up to MAX_RANK dimensions giving three strided
// element offsets per step.
// ----------------------------------------------------------------------------
// Each advance item produces one result, and a new item can be taken every
// cycle unless every stage holds an item and the result waits to be taken.
// The index is stepped and captured in the first register stage at the
// edge that accepts the item, the per-dimension index-times-stride products
// are registered in the second, and the sum with the base is registered in
// the third, which drives the result channel. Each stage holds its contents
// only while the stage after it is full, so items keep entering while a
// result waits to be taken until all three stages hold an item.
// Configuration writes are taken at any time; they are meant to be made
// while no item is in flight.
`default_nettype none

module strided_tensor_address_walker #(
    parameter int MAX_RANK    = 4,
    parameter int EXTENT_BITS = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stw_cfg_if.sink     i_cfg,
    stw_req_if.sink     i_req,
    stw_rsp_if.source   o_rsp
);

    localparam int USED_BITS = $clog2(MAX_RANK + 1);

    function automatic logic [stw_pkg::CFG_DATA_BITS-1:0] f_ext_reset();
        logic [stw_pkg::CFG_DATA_BITS-1:0] v;
        int unsigned                       sh;
        v = '0;
        for (int d = 0; d < MAX_RANK; d++) begin
            sh = (MAX_RANK - 1 - d) * EXTENT_BITS;
            if (sh < stw_pkg::CFG_DATA_BITS) begin
                v = v | (stw_pkg::CFG_DATA_BITS'(1) << sh);
            end
        end
        return v;
    endfunction

    localparam logic [stw_pkg::CFG_DATA_BITS-1:0] EXT_RESET = f_ext_reset();

    // Configuration registers
    logic [stw_pkg::RANK_BITS-1:0]      r_rank;
    logic [stw_pkg::CFG_DATA_BITS-1:0]  r_extents;
    logic [OFFSET_BITS-1:0]             r_a_base;
    logic [OFFSET_BITS-1:0]             r_b_base;
    logic [OFFSET_BITS-1:0]             r_dst_base;
    logic [stw_pkg::CFG_DATA_BITS-1:0]  r_a_strides;
    logic [stw_pkg::CFG_DATA_BITS-1:0]  r_b_strides;
    logic [stw_pkg::CFG_DATA_BITS-1:0]  r_out_strides;

    // Walk state and pipeline
    logic [MAX_RANK-1:0][EXTENT_BITS-1:0] r_cnt;
    logic [MAX_RANK-1:0][EXTENT_BITS-1:0] n_cnt;
    logic [MAX_RANK-1:0][EXTENT_BITS-1:0] r_s1_idx;
    logic [MAX_RANK-1:0][EXTENT_BITS-1:0] n_s1_idx;
    logic [MAX_RANK-1:0][EXTENT_BITS-1:0] ext_fld;
    logic [USED_BITS-1:0]                 used_rank;
    logic                                 step_last;
    logic                                 r_v1, r_v2, r_v3;
    logic                                 r_last1, r_last2, r_last3;
    logic                                 rdy1, rdy2, rdy3;
    logic                                 in_acc;

    // ---------------------------------------------------------------- config
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank        <= '0;
            r_extents     <= EXT_RESET;
            r_a_base      <= '0;
            r_b_base      <= '0;
            r_dst_base    <= '0;
            r_a_strides   <= '0;
            r_b_strides   <= '0;
            r_out_strides <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                stw_pkg::CFG_RANK:        r_rank        <= i_cfg.data[stw_pkg::RANK_BITS-1:0];
                stw_pkg::CFG_EXTENTS:     r_extents     <= i_cfg.data;
                stw_pkg::CFG_SRC_A_BASE:  r_a_base      <= i_cfg.data[OFFSET_BITS-1:0];
                stw_pkg::CFG_SRC_B_BASE:  r_b_base      <= i_cfg.data[OFFSET_BITS-1:0];
                stw_pkg::CFG_DST_BASE:    r_dst_base    <= i_cfg.data[OFFSET_BITS-1:0];
                stw_pkg::CFG_A_STRIDES:   r_a_strides   <= i_cfg.data;
                stw_pkg::CFG_B_STRIDES:   r_b_strides   <= i_cfg.data;
                stw_pkg::CFG_OUT_STRIDES: r_out_strides <= i_cfg.data;
                default: ;
            endcase
        end
    end

    for (genvar d = 0; d < MAX_RANK; d++) begin : g_ext
        localparam int unsigned SHIFT = (MAX_RANK - 1 - d) * EXTENT_BITS;
        assign ext_fld[d] = EXTENT_BITS'(stw_pkg::f_packed_field(r_extents, SHIFT,
                                                                 EXTENT_BITS));
    end

    // A rank above MAX_RANK walks MAX_RANK dimensions.
    always_comb begin
        if (int'(r_rank) > MAX_RANK) begin
            used_rank = USED_BITS'(MAX_RANK);
        end else begin
            used_rank = USED_BITS'(r_rank);
        end
    end

    // ------------------------------------------------------------ handshake
    assign rdy3        = !r_v3 || o_rsp.ready;
    assign rdy2        = !r_v2 || rdy3;
    assign rdy1        = !r_v1 || rdy2;
    assign i_req.ready = rdy1;
    assign in_acc      = i_req.valid && rdy1;

    // ------------------------------------------------------------ odometer
    // The innermost used dimension steps; a dimension whose next value
    // reaches its extent wraps to zero and carries outward. A carry out of
    // dimension zero (or no used dimension at all) marks the last index.
    always_comb begin
        logic [MAX_RANK-1:0][EXTENT_BITS-1:0] idx_eff;
        logic [MAX_RANK-1:0][EXTENT_BITS-1:0] stepped;
        logic [EXTENT_BITS:0]                 nx;
        logic [EXTENT_BITS-1:0]               ext;
        logic                                 carry;
        logic                                 wrap;
        idx_eff = i_req.restart ? '0 : r_cnt;
        stepped = idx_eff;
        carry   = 1'b1;
        for (int d = MAX_RANK - 1; d >= 0; d--) begin
            nx   = {1'b0, idx_eff[d]} + (EXTENT_BITS + 1)'(1);
            ext  = (ext_fld[d] == '0) ? EXTENT_BITS'(1) : ext_fld[d];
            wrap = (nx >= {1'b0, ext});
            if (d < int'(used_rank)) begin
                if (carry) begin
                    stepped[d] = wrap ? '0 : nx[EXTENT_BITS-1:0];
                end
                carry = carry && wrap;
            end
        end
        for (int d = 0; d < MAX_RANK; d++) begin
            n_s1_idx[d] = (d < int'(used_rank)) ? idx_eff[d] : '0;
        end
        step_last = carry;
        n_cnt     = carry ? '0 : stepped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
        end else begin
            if (in_acc) begin
                r_cnt <= n_cnt;
            end
            if (rdy1) begin
                r_v1 <= i_req.valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_idx <= n_s1_idx;
            r_last1  <= step_last;
        end
        if (rdy2) begin
            r_last2 <= r_last1;
        end
        if (rdy3) begin
            r_last3 <= r_last2;
        end
    end

    // ------------------------------------------------------------ offsets
    stw_offset_lane #(
        .MAX_RANK    (MAX_RANK),
        .EXTENT_BITS (EXTENT_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_lane_a (
        .i_clk     (i_clk),
        .i_ld_prod (rdy2),
        .i_ld_sum  (rdy3),
        .i_idx     (r_s1_idx),
        .i_strides (r_a_strides),
        .i_base    (r_a_base),
        .o_offset  (o_rsp.src_a_ofs)
    );

    stw_offset_lane #(
        .MAX_RANK    (MAX_RANK),
        .EXTENT_BITS (EXTENT_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_lane_b (
        .i_clk     (i_clk),
        .i_ld_prod (rdy2),
        .i_ld_sum  (rdy3),
        .i_idx     (r_s1_idx),
        .i_strides (r_b_strides),
        .i_base    (r_b_base),
        .o_offset  (o_rsp.src_b_ofs)
    );

    stw_offset_lane #(
        .MAX_RANK    (MAX_RANK),
        .EXTENT_BITS (EXTENT_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_lane_dst (
        .i_clk     (i_clk),
        .i_ld_prod (rdy2),
        .i_ld_sum  (rdy3),
        .i_idx     (r_s1_idx),
        .i_strides (r_out_strides),
        .i_base    (r_dst_base),
        .o_offset  (o_rsp.dst_ofs)
    );

    assign o_rsp.valid = r_v3;
    assign o_rsp.last  = r_last3;

    // ------------------------------------------------------------ checks
`ifndef ASSERT_OFF
    // The walk restarts from zero once its last index has been issued.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && step_last |=> r_cnt == '0)
        else $error("index counters not cleared after the last index");

    // A scalar walk marks every result last.
    a_scalar_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && r_rank == '0 |-> o_rsp.last)
        else $error("scalar result not marked last");

    // Input is refused only when every stage holds an item.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> r_v1 && r_v2 && r_v3)
        else $error("input stalled with an empty pipeline stage");
`endif

endmodule

`default_nettype wire
